/* rtl/core/gha_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gha_pkg
// Shared sizes, codes and types of the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

	// Table sizing
	localparam int SLOT_COUNT = 256;
	localparam int GEN_BITS   = 32;

	localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W      = IDX_W + 1;
	localparam int GEN_W      = GEN_BITS;

	// Port field widths
	localparam int PORT_IDX_W = 8;
	localparam int PORT_GEN_W = 32;
	localparam int DATA_W     = 40;

	// Compare widths wide enough for either operand
	localparam int CMP_W      = (CNT_W > PORT_IDX_W) ? CNT_W : PORT_IDX_W + 1;
	localparam int GCMP_W     = (GEN_W > PORT_GEN_W) ? GEN_W : PORT_GEN_W;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_CHECK   = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_STALE = 2'd2
	} status_t;

endpackage

`default_nettype wire

/* rtl/core/generational_handle_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Hands out slot handles (index + generation) from a LIFO free list, else a fresh index.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request: tuser = opcode (allocate, release, check),
//   tdata = slot_index and slot_generation. m_axis returns one response per
//   request: tuser = status, tdata = handle_index and handle_generation.
//   Generations live in a synchronous RAM, the free list in another.
//   Requests are processed one at a time by a small sequencer:
//     - allocate from fresh index, table full, rejected handle: no RAM read
//     - release or check of a plausible handle: one table read
//     - allocate from the free list: stack read, then table read
//   after which the response state loads the output register; the
//   sequencer is back in idle at that same edge, and a new request is
//   only accepted once the previous one has reached idle again. The output
//   register lets a new request be accepted while the previous response is
//   waiting. If m_axis stalls with a response pending, the next request
//   completes its work and holds in the response state until the register
//   frees.
//   Reset clears the issued count, the free-list top and the sequencer;
//   the RAMs need no clearing since only written entries are ever read.
// ----------------------------------------------------------------------------
module generational_handle_allocator
	import gha_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                s_axis_tvalid,
	output logic               s_axis_tready,
	input  wire  [DATA_W-1:0]  s_axis_tdata,   // [7:0] slot_index, [39:8] slot_generation
	input  wire  [1:0]         s_axis_tuser,   // [1:0] opcode
	output logic               m_axis_tvalid,
	input  wire                m_axis_tready,
	output logic [DATA_W-1:0]  m_axis_tdata,   // [7:0] handle_index, [39:8] handle_generation
	output logic [1:0]         m_axis_tuser    // [1:0] status
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_POP   = 5'b00010,
		S_GENRD = 5'b00100,
		S_CHK   = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	state_t                state_q, state_d;
	logic [CNT_W-1:0]      issued_q, issued_d;
	logic [CNT_W-1:0]      free_top_q, free_top_d;
	logic                  m_valid_q;

	// latched request
	logic [1:0]            op_q;
	logic [PORT_IDX_W-1:0] idx_q;
	logic [PORT_GEN_W-1:0] gen_q;
	logic [IDX_W-1:0]      slot_q;

	// response holding register
	logic                  res_ld;
	logic [1:0]            res_status_q, res_status_d;
	logic [PORT_IDX_W-1:0] res_idx_q, res_idx_d;
	logic [PORT_GEN_W-1:0] res_gen_q, res_gen_d;

	// memories
	logic [GEN_W-1:0]      gen_mem [SLOT_COUNT];
	logic [IDX_W-1:0]      stk_mem [SLOT_COUNT];
	logic                  gen_we, gen_re, stk_we, stk_re;
	logic [IDX_W-1:0]      gen_waddr, gen_raddr, stk_waddr, stk_raddr;
	logic [GEN_W-1:0]      gen_wdata, gen_rdata_q;
	logic [IDX_W-1:0]      stk_rdata_q;

	logic                  req_fire, out_free;
	logic [PORT_IDX_W-1:0] in_idx;
	logic [PORT_GEN_W-1:0] in_gen;
	logic [CMP_W-1:0]      in_idx_cmp, latched_idx_cmp;
	logic [CNT_W-1:0]      free_top_m1;
	logic [GEN_W-1:0]      gen_next;
	logic                  gen_match;

	assign in_idx          = s_axis_tdata[PORT_IDX_W-1:0];
	assign in_gen          = s_axis_tdata[DATA_W-1:PORT_IDX_W];
	assign s_axis_tready   = (state_q == S_IDLE);
	assign req_fire        = s_axis_tvalid && s_axis_tready;
	assign out_free        = !m_valid_q || m_axis_tready;
	assign in_idx_cmp      = CMP_W'(in_idx);
	assign latched_idx_cmp = CMP_W'(idx_q);
	assign free_top_m1     = free_top_q - 1'b1;

	// bumped generation, zero skipped on wrap
	always_comb begin
		gen_next = gen_rdata_q + 1'b1;
		if (gen_next == '0) begin
			gen_next = GEN_W'(1);
		end
	end

	assign gen_match = (GCMP_W'(gen_rdata_q) == GCMP_W'(gen_q));

	// sequencer
	always_comb begin
		state_d      = state_q;
		issued_d     = issued_q;
		free_top_d   = free_top_q;
		res_ld       = 1'b0;
		res_status_d = STAT_STALE;
		res_idx_d    = idx_q;
		res_gen_d    = '0;
		gen_we       = 1'b0;
		gen_waddr    = latched_idx_cmp[IDX_W-1:0];
		gen_wdata    = gen_next;
		gen_re       = 1'b0;
		gen_raddr    = in_idx_cmp[IDX_W-1:0];
		stk_we       = 1'b0;
		stk_waddr    = free_top_q[IDX_W-1:0];
		stk_re       = 1'b0;
		stk_raddr    = free_top_m1[IDX_W-1:0];

		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					res_ld    = 1'b1;
					res_idx_d = in_idx;
					state_d   = S_RESP;
					case (s_axis_tuser)
						OP_ALLOC: begin
							if (free_top_q != '0) begin
								stk_re     = 1'b1;
								free_top_d = free_top_m1;
								state_d    = S_POP;
							end else if (issued_q < CNT_W'(SLOT_COUNT)) begin
								gen_we       = 1'b1;
								gen_waddr    = issued_q[IDX_W-1:0];
								gen_wdata    = GEN_W'(1);
								issued_d     = issued_q + 1'b1;
								res_status_d = STAT_OK;
								res_idx_d    = PORT_IDX_W'(issued_q);
								res_gen_d    = PORT_GEN_W'(1);
							end else begin
								res_status_d = STAT_FULL;
								res_idx_d    = '0;
							end
						end
						OP_RELEASE, OP_CHECK: begin
							if (in_gen != '0 && in_idx_cmp < CMP_W'(issued_q)) begin
								gen_re  = 1'b1;
								state_d = S_CHK;
							end
						end
						default: begin
							res_status_d = STAT_STALE;
						end
					endcase
				end
			end
			S_POP: begin
				gen_re    = 1'b1;
				gen_raddr = stk_rdata_q;
				state_d   = S_GENRD;
			end
			S_GENRD: begin
				res_ld       = 1'b1;
				res_status_d = STAT_OK;
				res_idx_d    = PORT_IDX_W'(slot_q);
				res_gen_d    = PORT_GEN_W'(gen_rdata_q);
				state_d      = S_RESP;
			end
			S_CHK: begin
				res_ld  = 1'b1;
				state_d = S_RESP;
				if (gen_match) begin
					res_status_d = STAT_OK;
					res_gen_d    = gen_q;
					if (op_q == OP_RELEASE) begin
						gen_we = 1'b1;
						if (free_top_q < CNT_W'(SLOT_COUNT)) begin
							stk_we     = 1'b1;
							free_top_d = free_top_q + 1'b1;
						end
					end
				end
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			issued_q   <= '0;
			free_top_q <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			issued_q   <= issued_d;
			free_top_q <= free_top_d;
			if (state_q == S_RESP && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// request, response and output payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q  <= s_axis_tuser;
			idx_q <= in_idx;
			gen_q <= in_gen;
		end
		if (state_q == S_POP) begin
			slot_q <= stk_rdata_q;
		end
		if (res_ld) begin
			res_status_q <= res_status_d;
			res_idx_q    <= res_idx_d;
			res_gen_q    <= res_gen_d;
		end
		if (state_q == S_RESP && out_free) begin
			m_axis_tuser <= res_status_q;
			m_axis_tdata <= {res_gen_q, res_idx_q};
		end
	end

	// generation table
	always_ff @(posedge clk) begin
		if (gen_we) begin
			gen_mem[gen_waddr] <= gen_wdata;
		end
		if (gen_re) begin
			gen_rdata_q <= gen_mem[gen_raddr];
		end
	end

	// free-list stack
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= latched_idx_cmp[IDX_W-1:0];
		end
		if (stk_re) begin
			stk_rdata_q <= stk_mem[stk_raddr];
		end
	end

	assign m_axis_tvalid = m_valid_q;

endmodule

`default_nettype wire

/* rtl/core/gha_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gha_checker
// Port-level checks of the handle allocator, bound to the top level.
// ----------------------------------------------------------------------------
module gha_checker
	import gha_pkg::*;
(
	input wire               clk,
	input wire               arst_n,
	input wire               s_axis_tvalid,
	input wire               s_axis_tready,
	input wire [DATA_W-1:0]  s_axis_tdata,
	input wire [1:0]         s_axis_tuser,
	input wire               m_axis_tvalid,
	input wire               m_axis_tready,
	input wire [DATA_W-1:0]  m_axis_tdata,
	input wire [1:0]         m_axis_tuser
);

	// stalled response holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("response changed while stalled");

	// status is always a defined code
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == STAT_OK || m_axis_tuser == STAT_FULL ||
			m_axis_tuser == STAT_STALE))
		else $error("undefined status code");

	// a full table answers with a null handle
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == STAT_FULL |-> m_axis_tdata == '0)
		else $error("table-full response carries a handle");

	// a rejected handle gives generation zero
	a_stale: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == STAT_STALE |->
			m_axis_tdata[DATA_W-1:PORT_IDX_W] == '0)
		else $error("stale response carries a generation");

	// a new response only follows an accepted request
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("response without a request in flight");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (.*);

`default_nettype wire
